@@ hw/rtl/msc_pkg.sv @@
package msc_pkg;

   // Defaults and fixed field widths
   localparam int NUM_SERVOS_DEF = 4;
   localparam int ADDR_W         = 11;
   localparam int ANGLE_W        = 8;
   localparam int ELAPSED_W      = 9;
   localparam int SETTING_W      = 24;
   localparam int INDEX_W        = 2;
   localparam int CSR_ADDR_W     = 3;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 16;

   localparam logic [ANGLE_W-1:0]   ANGLE_CENTER = 8'd90;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 9'd511;
   localparam logic [ADDR_W-1:0]    BASE_RESET   = 11'd1;

   // Register indexes on the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_ADDRESS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SERVO0       = 3'd1;

   // Request kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_CLOSED = 2'd1,
      MODE_THROWN = 2'd2
   } mode_type;

   // Item token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              opcode;
      logic              hit;
      logic [ADDR_W-1:0] offset;
      logic              direction;
   } tok_type;

   // Status of one servo after the visit
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               powered;
      logic               moving;
      logic               store;
   } status_type;

endpackage

@@ hw/rtl/msc_cell.sv @@
module msc_cell #(
   parameter int IDX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_en,
   input  msc_pkg::tok_type                   tok_i,
   output msc_pkg::tok_type                   tok_o,
   input  logic                               set_we,
   input  logic [msc_pkg::SETTING_W-1:0]      set_data,
   output msc_pkg::status_type                status_o
);

   logic [msc_pkg::SETTING_W-1:0] setting_ff;
   logic [msc_pkg::ANGLE_W-1:0]   angle_ff, angle_in;
   msc_pkg::mode_type             mode_ff, mode_in;
   logic [msc_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                          power_ff, power_in;
   logic                          store;
   msc_pkg::tok_type              tok_ff;

   logic [msc_pkg::ANGLE_W-1:0]   closed_ang, thrown_ang, speed, goal, next_ang;
   logic [msc_pkg::ELAPSED_W-1:0] el_inc;

   assign closed_ang = setting_ff[7:0];
   assign thrown_ang = setting_ff[15:8];
   assign speed      = setting_ff[23:16];

   // Work out this servo's next state when the token visits
   always_comb begin
      angle_in   = angle_ff;
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      power_in   = power_ff;
      store      = 1'b0;
      goal       = (mode_ff == msc_pkg::MODE_THROWN) ? thrown_ang : closed_ang;
      el_inc     = (elapsed_ff == msc_pkg::ELAPSED_MAX) ? elapsed_ff
                                                        : elapsed_ff + 1'b1;
      if (angle_ff < goal) begin
         next_ang = angle_ff + 1'b1;
      end else if (angle_ff > goal) begin
         next_ang = angle_ff - 1'b1;
      end else begin
         next_ang = angle_ff;
      end
      if (tok_i.opcode == msc_pkg::OP_COMMAND) begin
         if (tok_i.hit && tok_i.offset == msc_pkg::ADDR_W'(IDX)) begin
            mode_in    = tok_i.direction ? msc_pkg::MODE_THROWN : msc_pkg::MODE_CLOSED;
            elapsed_in = '0;
            power_in   = 1'b1;
         end
      end else if (mode_ff != msc_pkg::MODE_IDLE) begin
         if ({1'b0, speed} >= el_inc) begin
            elapsed_in = el_inc;
         end else begin
            angle_in   = next_ang;
            elapsed_in = '0;
            if (next_ang == closed_ang || next_ang == thrown_ang) begin
               power_in = 1'b0;
               mode_in  = msc_pkg::MODE_IDLE;
               store    = 1'b1;
            end
         end
      end
   end

   // Hold servo state; update on a visit, take settings on a write
   always_ff @(posedge clock) begin
      if (reset) begin
         setting_ff <= '0;
         angle_ff   <= msc_pkg::ANGLE_CENTER;
         mode_ff    <= msc_pkg::MODE_IDLE;
         elapsed_ff <= '0;
         power_ff   <= 1'b0;
      end else begin
         if (set_we) begin
            setting_ff <= set_data;
         end
         if (step_en && tok_i.valid) begin
            angle_ff   <= angle_in;
            mode_ff    <= mode_in;
            elapsed_ff <= elapsed_in;
            power_ff   <= power_in;
         end
      end
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (step_en) begin
         tok_ff.valid <= tok_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         tok_ff.opcode    <= tok_i.opcode;
         tok_ff.hit       <= tok_i.hit;
         tok_ff.offset    <= tok_i.offset;
         tok_ff.direction <= tok_i.direction;
      end
   end

   assign tok_o           = tok_ff;
   assign status_o.angle   = angle_in;
   assign status_o.powered = power_in;
   assign status_o.moving  = (mode_in != msc_pkg::MODE_IDLE);
   assign status_o.store   = store;

endmodule

@@ hw/rtl/multi_servo_slew_controller.sv @@
// Channel   Direction  tdata (low bit up)                               tuser       tlast
// req_      in         address[10:0], direction[11], zero pad [15:12]   opcode      -
// rsp_      out        angle[7:0], powered[8], moving[9], store[10]     servo_index last
// csr_      in         write enable, register index, 24-bit data        -           -
//
// An item is registered, then a token walks the row of servo cells, one cell a
// cycle, each cell updating its own servo and giving one result. The walk holds
// while a result waits in the output register.
// Reset sets every servo to angle 90, idle and unpowered; base address to 1.
module multi_servo_slew_controller #(
   parameter int NUM_SERVOS = msc_pkg::NUM_SERVOS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [msc_pkg::REQ_DATA_W-1:0]    req_tdata,   // address, direction
   input  logic                              req_tuser,   // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [msc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // angle, powered, moving, store
   output logic [msc_pkg::INDEX_W-1:0]       rsp_tuser,   // servo_index
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [msc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [msc_pkg::SETTING_W-1:0]     csr_wdata
);

   msc_pkg::tok_type    tok [NUM_SERVOS+1];
   msc_pkg::status_type status [NUM_SERVOS];
   logic [NUM_SERVOS-1:0] active;

   logic [msc_pkg::ADDR_W-1:0] base_ff;
   msc_pkg::tok_type           item_ff;
   logic                       step_en;
   logic                       busy;
   logic [msc_pkg::ADDR_W:0]   diff;

   logic                       rsp_valid_ff;
   msc_pkg::status_type        rsp_stat_ff;
   logic [msc_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic                       rsp_last_ff;

   msc_pkg::status_type        sel_stat;
   logic [msc_pkg::INDEX_W-1:0] sel_idx;

   assign step_en = !rsp_valid_ff || rsp_tready;

   // Busy until the token has passed the last cell
   always_comb begin
      busy = item_ff.valid;
      for (int k = 0; k < NUM_SERVOS - 1; k++) begin
         busy = busy | tok[k+1].valid;
      end
   end

   assign req_tready = !busy;

   // Base address register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= msc_pkg::BASE_RESET;
      end else if (csr_we && csr_addr == msc_pkg::CSR_BASE_ADDRESS) begin
         base_ff <= csr_wdata[msc_pkg::ADDR_W-1:0];
      end
   end

   // Capture the transaction and decode the window
   assign diff = {1'b0, req_tdata[msc_pkg::ADDR_W-1:0]} - {1'b0, base_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         item_ff.valid <= 1'b1;
      end else if (step_en) begin
         item_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.opcode    <= req_tuser;
         item_ff.hit       <= !diff[msc_pkg::ADDR_W] &&
                              (diff[msc_pkg::ADDR_W-1:0] < msc_pkg::ADDR_W'(NUM_SERVOS));
         item_ff.offset    <= diff[msc_pkg::ADDR_W-1:0];
         item_ff.direction <= req_tdata[msc_pkg::ADDR_W];
      end
   end

   assign tok[0] = item_ff;

   // Row of servo cells
   for (genvar k = 0; k < NUM_SERVOS; k++) begin : g_cell
      assign active[k] = tok[k].valid;
      msc_cell #(.IDX(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_en  (step_en),
         .tok_i    (tok[k]),
         .tok_o    (tok[k+1]),
         .set_we   (csr_we && csr_addr == msc_pkg::CSR_SERVO0 +
                    msc_pkg::CSR_ADDR_W'(k)),
         .set_data (csr_wdata),
         .status_o (status[k])
      );
   end

   // Pick the status of the visited cell
   always_comb begin
      sel_stat = '0;
      sel_idx  = '0;
      for (int k = 0; k < NUM_SERVOS; k++) begin
         if (active[k]) begin
            sel_stat = sel_stat | status[k];
            sel_idx  = sel_idx | msc_pkg::INDEX_W'(k);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= |active;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_stat_ff <= sel_stat;
         rsp_idx_ff  <= sel_idx;
         rsp_last_ff <= active[NUM_SERVOS-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_stat_ff.store, rsp_stat_ff.moving,
                        rsp_stat_ff.powered, rsp_stat_ff.angle};
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
